@@ src/sha1_pkg.sv @@
package sha1_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } beat_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
  } digest_t;

endpackage

@@ src/sha1_front.sv @@
module sha1_front
  import sha1_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  beat_t beat_i,
  output logic  valid_o,
  input  logic  ready_i,
  output beat_t beat_o
);

  beat_t       mem_q [QDEPTH];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop, useful;

  // beats with neither byte nor end are dropped here
  assign useful  = beat_i.byte_present | beat_i.end_of_message;
  assign ready_o = (cnt_q != 2'(QDEPTH));
  assign push    = valid_i & ready_o & useful;
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o & ready_i;
  assign beat_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= beat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/sha1_core.sv @@
module sha1_core
  import sha1_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  beat_t   beat_i,
  output logic    valid_o,
  input  logic    ready_i,
  output digest_t digest_o
);

  typedef enum logic [2:0] {
    S_IN, S_PAD, S_LEN, S_RUN, S_FIN, S_OUT
  } state_e;

  state_e      state_q;
  logic [31:0] w_q [16];
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [6:0]  rnd_q;
  logic        padded_q;
  state_e      after_q;

  logic [31:0] f, k, t, wn;
  logic [3:0]  widx;
  logic [4:0]  sh;
  logic [31:0] bmask, bval;
  logic [7:0]  pbyte;

  assign ready_o  = (state_q == S_IN);
  assign valid_o  = (state_q == S_OUT);
  assign digest_o = '{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q; k = K3;
    end
    t  = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    wn = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wn = {wn[30:0], wn[31]};
    widx  = fill_q[5:2];
    sh    = 5'(24 - 8 * fill_q[1:0]);
    bmask = 32'hFF << sh;
    pbyte = (state_q == S_PAD && !padded_q) ? PAD_BYTE :
            (state_q == S_PAD) ? 8'h00 : beat_i.data_byte;
    bval  = 32'(pbyte) << sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IN;
      after_q  <= S_IN;
      h_q      <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
      fill_q   <= '0;
      len_q    <= '0;
      rnd_q    <= '0;
      padded_q <= 1'b0;
    end else begin
      case (state_q)
        S_IN: begin
          if (valid_i) begin
            padded_q <= 1'b0;
            if (beat_i.byte_present) begin
              w_q[widx] <= (fill_q[1:0] == 2'd0) ? bval : (w_q[widx] & ~bmask) | bval;
              fill_q    <= fill_q + 6'd1;
              len_q     <= len_q + 64'd8;
              if (fill_q == 6'd63) begin
                state_q <= S_RUN;
                after_q <= beat_i.end_of_message ? S_PAD : S_IN;
              end else if (beat_i.end_of_message) begin
                state_q <= S_PAD;
              end
            end else begin
              state_q <= S_PAD;
            end
            {a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
            rnd_q <= '0;
          end
        end
        S_PAD: begin
          // one byte per cycle: 0x80 then zeros up to 56 or to block end
          w_q[widx] <= (fill_q[1:0] == 2'd0) ? bval : (w_q[widx] & ~bmask) | bval;
          fill_q    <= fill_q + 6'd1;
          padded_q  <= 1'b1;
          {a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
          rnd_q <= '0;
          if (fill_q == 6'd63) begin
            state_q <= S_RUN;
            after_q <= S_PAD;
          end else if (fill_q == 6'd55) begin
            state_q <= S_LEN;
          end
        end
        S_LEN: begin
          w_q[14] <= len_q[63:32];
          w_q[15] <= len_q[31:0];
          fill_q  <= '0;
          state_q <= S_RUN;
          after_q <= S_OUT;
        end
        S_RUN: begin
          e_q <= d_q;
          d_q <= c_q;
          c_q <= {b_q[1:0], b_q[31:2]};
          b_q <= a_q;
          a_q <= t;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wn;
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) state_q <= S_FIN;
        end
        S_FIN: begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q;
          {a_q, b_q, c_q, d_q, e_q} <=
            {h_q[0] + a_q, h_q[1] + b_q, h_q[2] + c_q, h_q[3] + d_q, h_q[4] + e_q};
          rnd_q   <= '0;
          state_q <= after_q;
        end
        S_OUT: begin
          if (ready_i) begin
            h_q     <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
            fill_q  <= '0;
            len_q   <= '0;
            state_q <= S_IN;
          end
        end
        default: state_q <= S_IN;
      endcase
    end
  end

endmodule

@@ src/sha1_message_digest_unit.sv @@
// A byte beat writes one byte of the message block; a beat closing a 64-byte
// block adds 80 rounds (one per cycle in the round unit) plus a merge.
// End of message: padding bytes (0x80, then zeros), a length step, then one or
// two blocks through the rounds. The core takes no new byte while a block is in
// the single round unit. Reset (rst_ni low, asynchronous) loads the initial chain
// value and clears fill position, bit count and the input queue.
module sha1_message_digest_unit
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word0_o,
  output logic [31:0] digest_word1_o,
  output logic [31:0] digest_word2_o,
  output logic [31:0] digest_word3_o,
  output logic [31:0] digest_word4_o
);

  beat_t   in_beat, q_beat;
  logic    q_valid, q_ready;
  digest_t dig;

  assign in_beat = '{data_byte_i, byte_present_i, end_of_message_i};

  sha1_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o), .beat_i(in_beat),
    .valid_o(q_valid), .ready_i(q_ready), .beat_o(q_beat)
  );

  sha1_core u_core (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .ready_o(q_ready), .beat_i(q_beat),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .digest_o(dig)
  );

  assign digest_word0_o = dig.w0;
  assign digest_word1_o = dig.w1;
  assign digest_word2_o = dig.w2;
  assign digest_word3_o = dig.w3;
  assign digest_word4_o = dig.w4;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word0_o))
    else $error("digest changed while stalled");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !q_ready)
    else $error("core took a beat while holding a digest");

endmodule
